// ===== hdl/mipsx_pkg.sv =====
// Shared constants, decode codes and stage structures for the MIPS subset executor.
package mipsx_pkg;

   localparam int DATA_WORDS_DEF = 1024;

   // primary opcodes
   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_JAL   = 6'h03;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_SLTI  = 6'h0a;
   localparam logic [5:0] OP_ANDI  = 6'h0c;
   localparam logic [5:0] OP_ORI   = 6'h0d;
   localparam logic [5:0] OP_LUI   = 6'h0f;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SW    = 6'h2b;

   // R-type function codes
   localparam logic [5:0] FN_SLL = 6'h00;
   localparam logic [5:0] FN_SRL = 6'h02;
   localparam logic [5:0] FN_OR  = 6'h05;
   localparam logic [5:0] FN_JR  = 6'h08;
   localparam logic [5:0] FN_SLT = 6'h0a;
   localparam logic [5:0] FN_ADD = 6'h20;
   localparam logic [5:0] FN_SUB = 6'h22;
   localparam logic [5:0] FN_AND = 6'h24;

   localparam logic [5:0] DEST_NONE = 6'd63;
   localparam logic [4:0] REG_ZERO  = 5'd0;
   localparam logic [4:0] REG_ONE   = 5'd1;
   localparam logic [4:0] REG_LINK  = 5'd31;

   typedef struct packed {
      logic [25:0] pc;
      logic [5:0]  last_dest;
      logic [5:0]  second_dest;
      logic        last_load;
      logic        branch_pend;
      logic        jump_pend;
      logic        halt;
      logic [31:0] total;
   } arch_type;

   localparam arch_type ARCH_RESET = '{
      pc:          26'd0,
      last_dest:   DEST_NONE,
      second_dest: DEST_NONE,
      last_load:   1'b0,
      branch_pend: 1'b0,
      jump_pend:   1'b0,
      halt:        1'b0,
      total:       32'd0
   };

   typedef struct packed {
      logic        wr;
      logic [4:0]  idx;
      logic [31:0] val;
      logic        load;
      logic [1:0]  stall;
   } ex_res_type;

   typedef struct packed {
      logic        store;
      logic [31:0] addr;
      logic [31:0] data;
   } dmem_req_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  idx;
      logic [31:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic [25:0] pc;
      logic        halt;
      logic [31:0] total;
      ex_res_type  res;
   } mem_stage_type;

endpackage

// ===== hdl/mipsx_if.sv =====
// Valid/ready channel interfaces: instruction words, results and the config register.
interface mipsx_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction_word;

   modport source (output valid, output instruction_word, input ready);
   modport sink   (input valid, input instruction_word, output ready);
endinterface

interface mipsx_rsp_if;
   logic               valid;
   logic               ready;
   logic [25:0]        next_pc;
   logic [1:0]         stall_cycles;
   logic               reg_write;
   logic [4:0]         dest_index;
   logic signed [31:0] dest_value;
   logic               halted;
   logic [31:0]        total_stalls;

   modport source (output valid, output next_pc, output stall_cycles, output reg_write,
                   output dest_index, output dest_value, output halted,
                   output total_stalls, input ready);
   modport sink   (input valid, input next_pc, input stall_cycles, input reg_write,
                   input dest_index, input dest_value, input halted,
                   input total_stalls, output ready);
endinterface

interface mipsx_csr_if;
   logic valid;
   logic ready;
   logic forwarding_enabled;

   modport source (output valid, output forwarding_enabled, input ready);
   modport sink   (input valid, input forwarding_enabled, output ready);
endinterface

// ===== hdl/mipsx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mipsx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/mipsx_regfile.sv =====
// Register file: two RAM copies, per-entry valid bits and write bypass to the execute stage.
module mipsx_regfile (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [4:0]            rd_addr_a,
   input  logic [4:0]            rd_addr_b,
   input  mipsx_pkg::rf_wr_type  wr,
   output logic [31:0]           a_data,
   output logic [31:0]           b_data
);

   import mipsx_pkg::*;

   logic [31:0] valid_ff;
   logic [4:0]  addr_a_ff;
   logic [4:0]  addr_b_ff;
   logic        vld_a_ff;
   logic        vld_b_ff;
   rf_wr_type   snap_ff;
   logic [31:0] ram_a;
   logic [31:0] ram_b;

   mipsx_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
      .clock (clock),
      .we    (wr.en),
      .waddr (wr.idx),
      .wdata (wr.data),
      .re    (rd_en),
      .raddr (rd_addr_a),
      .rdata (ram_a)
   );

   mipsx_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
      .clock (clock),
      .we    (wr.en),
      .waddr (wr.idx),
      .wdata (wr.data),
      .re    (rd_en),
      .raddr (rd_addr_b),
      .rdata (ram_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   // the write committing at the read edge is missed by the RAM read, keep a copy
   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
         vld_a_ff  <= valid_ff[rd_addr_a];
         vld_b_ff  <= valid_ff[rd_addr_b];
         snap_ff   <= wr;
      end
   end

   always_comb begin
      if (wr.en && wr.idx == addr_a_ff) begin
         a_data = wr.data;
      end else if (snap_ff.en && snap_ff.idx == addr_a_ff) begin
         a_data = snap_ff.data;
      end else begin
         a_data = vld_a_ff ? ram_a : 32'd0;
      end

      if (wr.en && wr.idx == addr_b_ff) begin
         b_data = wr.data;
      end else if (snap_ff.en && snap_ff.idx == addr_b_ff) begin
         b_data = snap_ff.data;
      end else begin
         b_data = vld_b_ff ? ram_b : 32'd0;
      end
   end

endmodule

// ===== hdl/mipsx_exec.sv =====
// Execute stage logic: decode, ALU, branch/jump resolution and hazard stall accounting.
module mipsx_exec #(
   parameter int DATA_WORDS = mipsx_pkg::DATA_WORDS_DEF
) (
   input  logic [31:0]             word,
   input  logic [31:0]             op_a,
   input  logic [31:0]             op_b,
   input  logic                    fwd,
   input  mipsx_pkg::arch_type     st,
   output mipsx_pkg::arch_type     st_nx,
   output mipsx_pkg::ex_res_type   res,
   output mipsx_pkg::dmem_req_type dmem
);

   import mipsx_pkg::*;

   logic [5:0]  op;
   logic [4:0]  rs;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sh;
   logic [5:0]  fn;
   logic [31:0] imm;
   logic [25:0] pc_inc;
   logic [31:0] addr;
   logic        in_range;
   logic        ctl_busy;
   logic        jp_after;
   logic        rs_l;
   logic        rt_l;
   logic        rs_s;
   logic        rt_s;
   logic [5:0]  ld_tmp;
   logic [1:0]  stall;
   logic        dvld;
   logic [4:0]  didx;
   logic [31:0] val;
   logic        is_load;
   logic        wr;

   assign op       = word[31:26];
   assign rs       = word[25:21];
   assign rt       = word[20:16];
   assign rd       = word[15:11];
   assign sh       = word[10:6];
   assign fn       = word[5:0];
   assign imm      = {{16{word[15]}}, word[15:0]};
   assign pc_inc   = st.pc + 26'd1;
   assign addr     = op_a + imm;
   assign in_range = addr < 32'(DATA_WORDS);
   assign rs_l     = {1'b0, rs} == st.last_dest;
   assign rt_l     = {1'b0, rt} == st.last_dest;
   assign rs_s     = {1'b0, rs} == st.second_dest;
   assign rt_s     = {1'b0, rt} == st.second_dest;
   // a pending branch is consumed first, a pending jump only when no branch is
   assign ctl_busy = st.branch_pend || st.jump_pend;
   assign jp_after = st.branch_pend ? st.jump_pend : 1'b0;

   always_comb begin
      st_nx      = st;
      stall      = 2'd0;
      ld_tmp     = st.last_dest;
      dvld       = 1'b0;
      didx       = REG_ZERO;
      val        = 32'd0;
      is_load    = 1'b0;
      dmem.store = 1'b0;
      dmem.addr  = addr;
      dmem.data  = op_b;

      if (!st.halt) begin
         st_nx.pc = pc_inc;
         unique case (op)
            OP_RTYPE: begin
               st_nx.branch_pend = 1'b0;
               st_nx.jump_pend   = jp_after;
               if (ctl_busy) begin
                  stall = 2'd1;
               end else if (fwd) begin
                  if (st.last_load && (rs_l || rt_l)) begin
                     stall  = 2'd1;
                     ld_tmp = DEST_NONE;
                  end
               end else if (rs_l || rt_l) begin
                  stall  = 2'd2;
                  ld_tmp = DEST_NONE;
               end else if (rs_s || rt_s) begin
                  stall = 2'd1;
               end
               st_nx.second_dest = ld_tmp;
               st_nx.last_dest   = {1'b0, rd};
               st_nx.last_load   = 1'b0;
               dvld = 1'b1;
               didx = rd;
               unique case (fn)
                  FN_SLL: val = op_a << sh;
                  FN_SRL: val = 32'($signed(op_a) >>> sh);
                  FN_ADD: val = op_a + op_b;
                  FN_SUB: val = op_a - op_b;
                  FN_SLT: val = {31'd0, $signed(op_a) < $signed(op_b)};
                  FN_AND: val = op_a & op_b;
                  FN_OR:  val = op_a | op_b;
                  FN_JR: begin
                     st_nx.pc        = op_a[25:0];
                     st_nx.jump_pend = 1'b1;
                     dvld            = 1'b0;
                  end
                  default: val = 32'd0;
               endcase
            end
            OP_J, OP_JAL: begin
               st_nx.branch_pend = 1'b0;
               stall             = ctl_busy ? 2'd1 : 2'd0;
               st_nx.second_dest = st.last_dest;
               st_nx.last_dest   = DEST_NONE;
               st_nx.last_load   = 1'b0;
               if (op == OP_JAL) begin
                  dvld = 1'b1;
                  didx = REG_LINK;
                  val  = {6'd0, pc_inc};
               end
               st_nx.pc        = word[25:0];
               st_nx.jump_pend = 1'b1;
            end
            OP_ADDI, OP_ANDI, OP_ORI, OP_SLTI, OP_LUI, OP_BEQ, OP_BNE, OP_LW, OP_SW: begin
               st_nx.branch_pend = 1'b0;
               st_nx.jump_pend   = jp_after;
               if (ctl_busy) begin
                  stall = 2'd1;
               end else if (fwd) begin
                  // load-use stall here leaves the history as it is
                  if (st.last_load && rs_l) begin
                     stall = 2'd1;
                  end
               end else if (rs_l) begin
                  stall  = 2'd2;
                  ld_tmp = DEST_NONE;
               end else if (rs_s) begin
                  stall = 2'd1;
               end
               st_nx.second_dest = ld_tmp;
               st_nx.last_dest   = {1'b0, rt};
               st_nx.last_load   = (op == OP_LW);
               unique case (op)
                  OP_ADDI: begin
                     dvld = 1'b1;
                     didx = rt;
                     val  = addr;
                  end
                  OP_ANDI: begin
                     dvld = 1'b1;
                     didx = rt;
                     val  = op_a & imm;
                  end
                  OP_ORI: begin
                     dvld = 1'b1;
                     didx = rt;
                     val  = op_a | imm;
                  end
                  OP_SLTI: begin
                     dvld = 1'b1;
                     didx = rt;
                     val  = {31'd0, $signed(op_a) < $signed(imm)};
                  end
                  OP_LUI: begin
                     dvld = 1'b1;
                     didx = rt;
                     val  = {word[15:0], 16'd0};
                  end
                  OP_BEQ, OP_BNE: begin
                     if ((op == OP_BEQ) == (op_a == op_b)) begin
                        st_nx.pc          = st.pc + imm[25:0];
                        st_nx.branch_pend = 1'b1;
                     end
                  end
                  OP_LW: begin
                     if (in_range) begin
                        dvld    = 1'b1;
                        didx    = rt;
                        is_load = 1'b1;
                     end
                  end
                  OP_SW: dmem.store = in_range;
                  default: ;
               endcase
            end
            default: ;
         endcase

         if (dvld && didx == REG_ZERO) begin
            st_nx.halt = 1'b1;
         end
         st_nx.total = st.total + 32'(stall);
      end
   end

   assign wr        = dvld && didx != REG_ZERO && didx != REG_ONE;
   assign res.wr    = wr;
   assign res.idx   = wr ? didx : REG_ZERO;
   assign res.val   = wr ? val : 32'd0;
   assign res.load  = wr && is_load;
   assign res.stall = stall;

endmodule

// ===== hdl/mips_subset_execute_with_hazard_stalls.sv =====
// MIPS subset executor: one instruction word in, one result word out, with stall accounting.
//
// req_ch carries one instruction word, the one at the current program counter.
// rsp_ch returns one word per instruction: next PC, stall cycles charged, the
// register write (if any), halted flag and the running stall total.
// csr_ch writes forwarding_enabled; it is always ready and is meant to be
// written only while no instruction is in flight.
//
// Path: a word accepted on req_ch is registered into execute (operand fetch), then
// into the result stage (data-store read / write back) and presented on rsp_ch.
// Throughput is one word per cycle while rsp_ch keeps up; the execute stage reads
// register operands with bypass from the two most recent write backs.
// After reset the data store is cleared one word per cycle, and req_ch.ready is
// low until that sweep is done. Each stage moves on when the one after it
// is empty or moving, so a stalled receiver backs the pipe up one stage at a
// time; an empty execute stage still accepts a word while a result waits.
module mips_subset_execute_with_hazard_stalls #(
   parameter int DATA_WORDS = mipsx_pkg::DATA_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mipsx_req_if.sink   req_ch,
   mipsx_rsp_if.source rsp_ch,
   mipsx_csr_if.sink   csr_ch
);

   import mipsx_pkg::*;

   localparam int AW = $clog2(DATA_WORDS);

   logic          clr_busy_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic          fwd_ff;
   arch_type      arch_ff;
   arch_type      arch_nx;
   logic          x_valid_ff;
   logic [31:0]   x_word_ff;
   logic          m_valid_ff;
   mem_stage_type m_ff;
   logic          m_adv;
   logic          x_adv;
   logic          x_fire;
   logic          req_fire;
   logic [31:0]   op_a;
   logic [31:0]   op_b;
   ex_res_type    ex_res;
   dmem_req_type  dmem;
   rf_wr_type     rf_wr;
   logic [31:0]   dmem_rdata;
   logic [31:0]   m_wdata;
   logic          dm_we;
   logic [AW-1:0] dm_waddr;
   logic [31:0]   dm_wdata;

   assign m_adv         = !m_valid_ff || rsp_ch.ready;
   assign x_adv         = !x_valid_ff || m_adv;
   assign x_fire        = x_valid_ff && x_adv;
   assign req_ch.ready  = x_adv && !clr_busy_ff;
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         if (clr_cnt_ff == AW'(DATA_WORDS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         fwd_ff <= csr_ch.forwarding_enabled;
      end
   end

   // operand fetch: addresses come straight off the request word
   mipsx_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr_a (req_ch.instruction_word[25:21]),
      .rd_addr_b (req_ch.instruction_word[20:16]),
      .wr        (rf_wr),
      .a_data    (op_a),
      .b_data    (op_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else if (x_adv) begin
         x_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_word_ff <= req_ch.instruction_word;
      end
   end

   mipsx_exec #(.DATA_WORDS(DATA_WORDS)) u_exec (
      .word  (x_word_ff),
      .op_a  (op_a),
      .op_b  (op_b),
      .fwd   (fwd_ff),
      .st    (arch_ff),
      .st_nx (arch_nx),
      .res   (ex_res),
      .dmem  (dmem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff <= ARCH_RESET;
      end else if (x_fire) begin
         arch_ff <= arch_nx;
      end
   end

   // data store; the clearing sweep owns the write port until done
   assign dm_we    = clr_busy_ff || (x_fire && dmem.store);
   assign dm_waddr = clr_busy_ff ? clr_cnt_ff : dmem.addr[AW-1:0];
   assign dm_wdata = clr_busy_ff ? 32'd0 : dmem.data;

   // read only as the word moves on, so load data holds while the result waits
   mipsx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dstore (
      .clock (clock),
      .we    (dm_we),
      .waddr (dm_waddr),
      .wdata (dm_wdata),
      .re    (x_fire),
      .raddr (dmem.addr[AW-1:0]),
      .rdata (dmem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_adv) begin
         m_valid_ff <= x_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (x_fire) begin
         m_ff.pc    <= arch_nx.pc;
         m_ff.halt  <= arch_nx.halt;
         m_ff.total <= arch_nx.total;
         m_ff.res   <= ex_res;
      end
   end

   assign m_wdata    = m_ff.res.load ? dmem_rdata : m_ff.res.val;
   // rewriting the same entry while the result waits is harmless
   assign rf_wr.en   = m_valid_ff && m_ff.res.wr;
   assign rf_wr.idx  = m_ff.res.idx;
   assign rf_wr.data = m_wdata;

   assign rsp_ch.valid        = m_valid_ff;
   assign rsp_ch.next_pc      = m_ff.pc;
   assign rsp_ch.stall_cycles = m_ff.res.stall;
   assign rsp_ch.reg_write    = m_ff.res.wr;
   assign rsp_ch.dest_index   = m_ff.res.idx;
   assign rsp_ch.dest_value   = $signed(m_wdata);
   assign rsp_ch.halted       = m_ff.halt;
   assign rsp_ch.total_stalls = m_ff.total;

endmodule

// ===== hdl/mipsx_checker.sv =====
// Port-level checker for the MIPS subset executor and its bind to the top level.
module mipsx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_stall_cycles,
   input logic        rsp_reg_write,
   input logic        rsp_halted,
   input logic [31:0] rsp_total_stalls
);

   logic        req_fire;
   logic        rsp_fire;
   logic [1:0]  pend_ff;
   logic        seen_halt_ff;
   logic [31:0] prev_total_ff;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 2'd0;
         seen_halt_ff  <= 1'b0;
         prev_total_ff <= 32'd0;
      end else begin
         pend_ff <= pend_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
         if (rsp_fire) begin
            seen_halt_ff  <= seen_halt_ff || rsp_halted;
            prev_total_ff <= rsp_total_stalls;
         end
      end
   end

   // once halted, every later word stays halted, writes nothing, charges nothing
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && seen_halt_ff) |-> (rsp_halted && !rsp_reg_write && rsp_stall_cycles == 2'd0))
      else $error("halted block reported activity");

   a_total_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_total_stalls == prev_total_ff + 32'(rsp_stall_cycles)))
      else $error("stall total does not match charged stalls");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("result word without an accepted instruction");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("instruction accepted during data store clear");

endmodule

bind mips_subset_execute_with_hazard_stalls mipsx_checker u_mipsx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_stall_cycles (rsp_ch.stall_cycles),
   .rsp_reg_write    (rsp_ch.reg_write),
   .rsp_halted       (rsp_ch.halted),
   .rsp_total_stalls (rsp_ch.total_stalls)
);

// ===== tb/tb_mips_subset_execute_with_hazard_stalls.sv =====
// Self-checking testbench for the MIPS subset executor and its hazard stall accounting.
`timescale 1ns / 100ps

module tb_mips_subset_execute_with_hazard_stalls;
   import mipsx_pkg::*;

   localparam int DWORDS     = DATA_WORDS_DEF;
   localparam int DAW        = $clog2(DWORDS);
   localparam int IDLE_LIMIT = 5000;
   localparam int REPORT_MAX = 10;

   localparam logic [5:0] OP_UNUSED = 6'h3f;
   localparam logic [5:0] FN_UNUSED = 6'h3f;

   typedef struct packed {
      logic [25:0] next_pc;
      logic [1:0]  stall;
      logic        wr;
      logic [4:0]  idx;
      logic [31:0] val;
      logic        halted;
      logic [31:0] total;
   } exec_result_type;

   logic clock;
   logic reset;

   mipsx_req_if req_ch ();
   mipsx_rsp_if rsp_ch ();
   mipsx_csr_if csr_ch ();

   mips_subset_execute_with_hazard_stalls u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // architectural copy kept by the testbench monitor for prediction
   logic [25:0] pc_m;
   logic [31:0] gpr [32];
   logic [31:0] dmem [DWORDS];
   logic [5:0]  ld;
   logic [5:0]  sld;
   bit          last_load;
   bit          br_pend;
   bit          jmp_pend;
   bit          halt_m;
   logic [31:0] stall_sum;
   bit          fwd_m;

   logic [31:0]     fetch_words [$];
   exec_result_type pending_results [$];
   bit              word_on_bus;
   int              send_idle_pct;
   int              recv_stall_pct;
   int              words_issued;
   int              results_checked;
   int              failures;
   int              idle_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sh, logic [5:0] fn);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
      return {op, target};
   endfunction

   // append one word to the fetch queue
   task automatic queue_word(logic [31:0] w);
      fetch_words.insert(fetch_words.size(), w);
   endtask

   // a pending taken branch (else a pending jump) is cleared and charges the next instruction a stall
   function automatic bit charge_redirect();
      if (br_pend) begin
         br_pend = 1'b0;
         return 1'b1;
      end
      if (jmp_pend) begin
         jmp_pend = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic exec_result_type execute_word(logic [31:0] w);
      logic [5:0]      op;
      logic [5:0]      fn;
      logic [4:0]      rs;
      logic [4:0]      rt;
      logic [4:0]      rd;
      logic [4:0]      sh;
      logic [31:0]     imm;
      logic [31:0]     a;
      logic [31:0]     b;
      logic [31:0]     addr;
      logic [31:0]     val;
      logic [25:0]     cur;
      logic [1:0]      stall;
      int              dest;
      exec_result_type r;

      r = '0;
      if (halt_m) begin
         r.next_pc = pc_m;
         r.halted  = 1'b1;
         r.total   = stall_sum;
         return r;
      end
      op    = w[31:26];
      rs    = w[25:21];
      rt    = w[20:16];
      rd    = w[15:11];
      sh    = w[10:6];
      fn    = w[5:0];
      imm   = {{16{w[15]}}, w[15:0]};
      cur   = pc_m;
      pc_m  = cur + 26'd1;
      stall = 2'd0;
      val   = '0;
      dest  = -1;

      if (op == OP_RTYPE) begin
         if (charge_redirect()) begin
            stall = 2'd1;
         end else if (fwd_m) begin
            if (last_load && ({1'b0, rs} == ld || {1'b0, rt} == ld)) begin
               stall = 2'd1;
               ld    = DEST_NONE;
            end
         end else if ({1'b0, rs} == ld || {1'b0, rt} == ld) begin
            stall = 2'd2;
            ld    = DEST_NONE;
         end else if ({1'b0, rs} == sld || {1'b0, rt} == sld) begin
            stall = 2'd1;
         end
         sld  = ld;
         ld   = {1'b0, rd};
         a    = gpr[rs];
         b    = gpr[rt];
         dest = int'(rd);
         case (fn)
            FN_SLL: val = a << sh;
            FN_SRL: val = $signed(a) >>> sh;
            FN_ADD: val = a + b;
            FN_SUB: val = a - b;
            FN_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            FN_AND: val = a & b;
            FN_OR:  val = a | b;
            FN_JR: begin
               pc_m     = a[25:0];
               jmp_pend = 1'b1;
               dest     = -1;
            end
            default: val = '0;
         endcase
         last_load = 1'b0;
      end else if (op == OP_J || op == OP_JAL) begin
         if (charge_redirect()) stall = 2'd1;
         sld = ld;
         ld  = DEST_NONE;
         if (op == OP_JAL) begin
            dest = int'(REG_LINK);
            val  = {6'd0, pc_m};
         end
         pc_m      = w[25:0];
         jmp_pend  = 1'b1;
         last_load = 1'b0;
      end else if (op inside {OP_ADDI, OP_ANDI, OP_ORI, OP_BNE, OP_BEQ, OP_SLTI, OP_LUI,
                              OP_LW, OP_SW}) begin
         if (charge_redirect()) begin
            stall = 2'd1;
         end else if (fwd_m) begin
            if (last_load && {1'b0, rs} == ld) stall = 2'd1;
         end else if ({1'b0, rs} == ld) begin
            stall = 2'd2;
            ld    = DEST_NONE;
         end else if ({1'b0, rs} == sld) begin
            stall = 2'd1;
         end
         sld  = ld;
         ld   = {1'b0, rt};
         a    = gpr[rs];
         b    = gpr[rt];
         addr = a + imm;
         case (op)
            OP_ADDI: begin dest = int'(rt); val = a + imm; end
            OP_ANDI: begin dest = int'(rt); val = a & imm; end
            OP_ORI:  begin dest = int'(rt); val = a | imm; end
            OP_SLTI: begin
               dest = int'(rt);
               val  = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
            end
            OP_LUI:  begin dest = int'(rt); val = {w[15:0], 16'd0}; end
            OP_BEQ, OP_BNE: begin
               if ((op == OP_BEQ) == (a == b)) begin
                  pc_m    = cur + imm[25:0];
                  br_pend = 1'b1;
               end
            end
            OP_LW: begin
               if (addr < DWORDS) begin
                  dest = int'(rt);
                  val  = dmem[addr[DAW-1:0]];
               end
            end
            default: begin
               if (addr < DWORDS) dmem[addr[DAW-1:0]] = b;
            end
         endcase
         last_load = (op == OP_LW);
      end

      if (dest == 0) halt_m = 1'b1;
      if (dest >= 2) begin
         r.wr       = 1'b1;
         r.idx      = 5'(dest);
         r.val      = val;
         gpr[r.idx] = val;
      end
      stall_sum += 32'(stall);
      r.next_pc = pc_m;
      r.stall   = stall;
      r.halted  = halt_m;
      r.total   = stall_sum;
      return r;
   endfunction

   // dependency-heavy register picks
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(99) < 60) return 5'($urandom_range(2, 5));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [4:0] pick_dest();
      if ($urandom_range(99) < 60) return 5'($urandom_range(2, 5));
      return 5'($urandom_range(1, 31));
   endfunction

   function automatic logic [4:0] mem_base();
      if ($urandom_range(99) < 80) return 5'($urandom_range(0, 1));
      return pick_reg();
   endfunction

   function automatic logic [15:0] mem_offset();
      int roll;

      roll = $urandom_range(99);
      if (roll < 50) return 16'($urandom_range(0, 63));
      if (roll < 80) return 16'($urandom_range(0, DWORDS - 1));
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      logic [5:0]  op;
      logic [5:0]  fn;
      int          roll;

      roll = $urandom_range(99);
      if (roll < 72) begin
         case ($urandom_range(20))
            0:  w = enc_r(pick_reg(), pick_reg(), pick_dest(), 5'($urandom), FN_SLL);
            1:  w = enc_r(pick_reg(), pick_reg(), pick_dest(), 5'($urandom), FN_SRL);
            2:  w = enc_r(pick_reg(), pick_reg(), pick_dest(), 5'($urandom), FN_ADD);
            3:  w = enc_r(pick_reg(), pick_reg(), pick_dest(), 5'($urandom), FN_SUB);
            4:  w = enc_r(pick_reg(), pick_reg(), pick_dest(), 5'($urandom), FN_SLT);
            5:  w = enc_r(pick_reg(), pick_reg(), pick_dest(), 5'($urandom), FN_AND);
            6:  w = enc_r(pick_reg(), pick_reg(), pick_dest(), 5'($urandom), FN_OR);
            7:  w = enc_r(pick_reg(), pick_reg(), 5'($urandom), 5'($urandom), FN_JR);
            8:  w = enc_i(OP_ADDI, pick_reg(), pick_dest(), 16'($urandom));
            9:  w = enc_i(OP_ANDI, pick_reg(), pick_dest(), 16'($urandom));
            10: w = enc_i(OP_ORI, pick_reg(), pick_dest(), 16'($urandom));
            11: w = enc_i(OP_SLTI, pick_reg(), pick_dest(), 16'($urandom));
            12: w = enc_i(OP_LUI, pick_reg(), pick_dest(), 16'($urandom));
            13, 14: w = enc_i(OP_LW, mem_base(), pick_dest(), mem_offset());
            15, 16: w = enc_i(OP_SW, mem_base(), pick_reg(), mem_offset());
            17: w = enc_i(OP_BEQ, pick_reg(), pick_reg(), 16'($urandom));
            18: w = enc_i(OP_BNE, pick_reg(), pick_reg(), 16'($urandom));
            19: w = enc_j(OP_J, 26'($urandom));
            default: w = enc_j(OP_JAL, 26'($urandom));
         endcase
      end else if (roll < 82) begin
         if ($urandom_range(1) == 1) begin
            do op = 6'($urandom); while (op inside {OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE,
                                                   OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI,
                                                   OP_LUI, OP_LW, OP_SW});
            w = {op, 26'($urandom)};
         end else begin
            do fn = 6'($urandom); while (fn inside {FN_SLL, FN_SRL, FN_OR, FN_JR, FN_SLT,
                                                   FN_ADD, FN_SUB, FN_AND});
            w = enc_r(pick_reg(), pick_reg(), pick_dest(), 5'($urandom), fn);
         end
      end else begin
         w = $urandom;
      end
      // keep r0 out of reach until the deliberate halt at the end
      if (w[31:26] == OP_RTYPE && w[5:0] != FN_JR && w[15:11] == REG_ZERO)
         w[15:11] = 5'($urandom_range(1, 31));
      else if (w[31:26] inside {OP_ADDI, OP_ANDI, OP_ORI, OP_SLTI, OP_LUI, OP_LW} &&
               w[20:16] == REG_ZERO)
         w[20:16] = 5'($urandom_range(1, 31));
      return w;
   endfunction

   // driver: present the next word, and the receiver's ready, at the falling edge
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!word_on_bus) begin
         if (fetch_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid            <= 1'b1;
            req_ch.instruction_word <= fetch_words[0];
            word_on_bus = 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: check results, then predict for the word just taken
   always @(posedge clock) begin
      exec_result_type got;
      exec_result_type want;

      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{next_pc: rsp_ch.next_pc, stall: rsp_ch.stall_cycles,
                    wr: rsp_ch.reg_write, idx: rsp_ch.dest_index, val: rsp_ch.dest_value,
                    halted: rsp_ch.halted, total: rsp_ch.total_stalls};
            if (pending_results.size() == 0) begin
               failures++;
               if (failures <= REPORT_MAX)
                  $display("%0t: result word with nothing expected: pc=%h", $realtime,
                           got.next_pc);
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (got !== want) begin
                  failures++;
                  if (failures <= REPORT_MAX)
                     $display({"%0t: mismatch on result %0d\n",
                               "  expected pc=%h stall=%0d wr=%b rd=%0d val=%h halt=%b tot=%0d\n",
                               "  actual   pc=%h stall=%0d wr=%b rd=%0d val=%h halt=%b tot=%0d"},
                              $realtime, results_checked,
                              want.next_pc, want.stall, want.wr, want.idx, want.val,
                              want.halted, want.total,
                              got.next_pc, got.stall, got.wr, got.idx, got.val,
                              got.halted, got.total);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want = execute_word(req_ch.instruction_word);
            pending_results.insert(pending_results.size(), want);
            void'(fetch_words.pop_front());
            word_on_bus = 1'b0;
            words_issued++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (fetch_words.size() != 0 || word_on_bus || pending_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_forwarding(bit enable);
      csr_ch.valid              <= 1'b1;
      csr_ch.forwarding_enabled <= enable;
      do @(posedge clock); while (!csr_ch.ready);
      fwd_m = enable;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // load followed by a dependent consumer now and then, otherwise one random word
   task automatic run_phase(bit enable, int send_pct, int recv_pct, int count);
      int          left;
      logic [4:0]  r;

      wait_drained();
      write_forwarding(enable);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      left = count;
      while (left > 0) begin
         if (left >= 2 && $urandom_range(99) < 20) begin
            r = 5'($urandom_range(2, 31));
            queue_word(enc_i(OP_LW, 5'($urandom_range(0, 1)), r,
                             16'($urandom_range(0, 63))));
            if ($urandom_range(1) == 1)
               queue_word(enc_r(r, pick_reg(), pick_dest(), 5'($urandom), FN_ADD));
            else
               queue_word(enc_i(OP_ADDI, r, pick_dest(), 16'($urandom)));
            left -= 2;
         end else begin
            queue_word(random_word());
            left--;
         end
      end
   endtask

   initial begin
      reset                     = 1'b1;
      req_ch.valid              = 1'b0;
      req_ch.instruction_word   = '0;
      rsp_ch.ready              = 1'b0;
      csr_ch.valid              = 1'b0;
      csr_ch.forwarding_enabled = 1'b0;
      word_on_bus               = 1'b0;
      send_idle_pct             = 0;
      recv_stall_pct            = 0;
      words_issued              = 0;
      results_checked           = 0;
      failures                  = 0;
      idle_cycles               = 0;
      pc_m                      = '0;
      ld                        = DEST_NONE;
      sld                       = DEST_NONE;
      last_load                 = 1'b0;
      br_pend                   = 1'b0;
      jmp_pend                  = 1'b0;
      halt_m                    = 1'b0;
      stall_sum                 = '0;
      fwd_m                     = 1'b0;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_forwarding(1'b0);
      queue_word(enc_i(OP_LUI, REG_ZERO, 5'd2, 16'h8000));
      queue_word(enc_i(OP_ORI, REG_ZERO, 5'd3, 16'hffff));
      queue_word(enc_i(OP_ADDI, 5'd2, 5'd4, 16'h7fff));
      queue_word(enc_r(5'd3, REG_ZERO, 5'd5, 5'd31, FN_SLL));
      queue_word(enc_r(5'd2, REG_ZERO, 5'd6, 5'd31, FN_SRL));
      queue_word(enc_r(5'd2, 5'd2, 5'd7, 5'd0, FN_ADD));
      queue_word(enc_r(REG_ZERO, 5'd2, 5'd8, 5'd0, FN_SUB));
      queue_word(enc_r(5'd2, 5'd3, 5'd9, 5'd0, FN_SLT));
      queue_word(enc_r(5'd3, 5'd2, 5'd10, 5'd0, FN_AND));
      queue_word(enc_r(5'd2, 5'd4, 5'd11, 5'd0, FN_OR));
      queue_word(enc_i(OP_SLTI, 5'd2, 5'd12, 16'hffff));
      queue_word(enc_i(OP_ANDI, 5'd3, 5'd13, 16'h8000));
      queue_word(enc_i(OP_SW, REG_ZERO, 5'd3, 16'(DWORDS - 1)));
      queue_word(enc_i(OP_LW, REG_ZERO, 5'd14, 16'(DWORDS - 1)));
      queue_word(enc_r(5'd14, 5'd14, 5'd15, 5'd0, FN_ADD));
      queue_word(enc_i(OP_LW, REG_ZERO, 5'd16, 16'(DWORDS)));
      queue_word(enc_i(OP_SW, 5'd3, 5'd2, 16'h0000));
      queue_word(enc_i(OP_ADDI, REG_ZERO, REG_ONE, 16'd5));
      queue_word(enc_r(REG_ONE, REG_ONE, 5'd17, 5'd0, FN_ADD));
      queue_word(enc_i(OP_BEQ, REG_ZERO, REG_ZERO, 16'd5));
      queue_word(enc_i(OP_BNE, REG_ZERO, REG_ZERO, 16'hfff0));
      queue_word(enc_i(OP_BNE, 5'd2, REG_ZERO, 16'hfff0));
      queue_word(enc_j(OP_J, 26'h3ffffff));
      queue_word(enc_j(OP_UNUSED, 26'h2aaaaaa));
      queue_word(enc_r(5'd2, 5'd3, 5'd18, 5'd0, FN_UNUSED));
      queue_word(enc_j(OP_JAL, 26'd0));
      queue_word(enc_r(5'd3, REG_ZERO, 5'd19, 5'd0, FN_JR));

      run_phase(1'b1, 0, 0, 300);
      run_phase(1'b0, 76, 0, 300);
      run_phase(1'b1, 0, 76, 300);
      run_phase(1'b0, 31, 31, 300);
      run_phase(1'b1, 31, 31, 250);
      run_phase(1'b0, 0, 0, 250);

      // all-zero word is sll into r0: block halts and ignores what follows
      wait_drained();
      send_idle_pct  = 31;
      recv_stall_pct = 31;
      queue_word('0);
      repeat (6) queue_word(random_word());

      wait_drained();
      repeat (8) @(negedge clock);
      failures += pending_results.size();

      $display("Ran %0d instruction words (directed, then random under both hazard modes",
               words_issued);
      $display("and four idling mixes, ending in a halt); %0d results checked, %0d stalls",
               results_checked, stall_sum);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures", failures);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
